// File: hw/rtl/qmr_pkg.sv
package qmr_pkg;

   // fixed point format: signed Q3.12 in 16 bits
   localparam int QBits    = 16;
   localparam int QFrac    = 12;
   localparam int OpBits   = QBits + 1;     // operand wide enough to hold +8.0
   localparam int ProdBits = 2 * OpBits;    // exact product
   localparam int SumBits  = ProdBits + 2;  // exact sum of four products

   localparam logic signed [SumBits-1:0] RoundHalf = SumBits'(1) <<< (QFrac - 1);
   localparam logic signed [SumBits-QFrac-1:0] QMax = (SumBits-QFrac)'(32767);
   localparam logic signed [SumBits-QFrac-1:0] QMin = -(SumBits-QFrac)'(32768);

   // rotate / product selector
   typedef enum logic {
      MODE_PRODUCT = 1'b0,
      MODE_ROTATE  = 1'b1
   } mode_type;

   typedef logic signed [QBits-1:0]   q16_type;
   typedef logic signed [OpBits-1:0]  q17_type;
   typedef logic signed [SumBits-1:0] qsum_type;

   typedef struct packed {
      q16_type w;
      q16_type x;
      q16_type y;
      q16_type z;
   } quat16_type;

   typedef struct packed {
      q17_type w;
      q17_type x;
      q17_type y;
      q17_type z;
   } quat17_type;

   typedef struct packed {
      qsum_type w;
      qsum_type x;
      qsum_type y;
      qsum_type z;
   } quatsum_type;

   typedef struct packed {
      q16_type value;
      logic    sat;
   } rounded_type;

   // round half up to Q3.12 and saturate to 16 bits
   function automatic rounded_type round_sat(input qsum_type sum);
      qsum_type                        biased;
      logic signed [SumBits-QFrac-1:0] shifted;
      rounded_type                     res;
      biased  = sum + RoundHalf;
      shifted = biased[SumBits-1:QFrac];
      if (shifted > QMax) begin
         res.value = 16'sh7fff;
         res.sat   = 1'b1;
      end else if (shifted < QMin) begin
         res.value = 16'sh8000;
         res.sat   = 1'b1;
      end else begin
         res.value = shifted[QBits-1:0];
         res.sat   = 1'b0;
      end
      return res;
   endfunction

   // widen a Q3.12 value by one bit
   function automatic q17_type widen(input q16_type v);
      return {v[QBits-1], v};
   endfunction

endpackage

// File: hw/rtl/quaternion_multiply_rotate.sv
// Quaternion product / vector rotation in signed Q3.12.
// Input channel req_*: one transfer carries quaternions a and b plus the mode
// bit in req_tuser (0 = Hamilton product a*b, 1 = rotate vector (b_x,b_y,b_z)
// by a, b_w ignored). Result channel rsp_*: one transfer per input transfer,
// in order, with the saturation flag in rsp_tuser; r_w is zero when rotating.
// Throughput: one transfer per cycle while the skid slot is empty.
// The datapath is seven register stages: input, first product array, first
// sums, rounding of t, second product array, second sums, final rounding,
// followed by the output register. Each product array stage holds sixteen
// 17x17 multiplies and each sum stage four four-term adds.
// Reset (synchronous, active high) empties every stage; no configuration.
// When the receiver stalls, the result in the output register holds and one
// more finished result parks in a skid slot; req_tready then drops for as
// long as the slot is full and the whole pipeline freezes, losing nothing.
module quaternion_multiply_rotate
   import qmr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
   input  logic         req_tuser,   // mode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // r_w, r_x, r_y, r_z
   output logic         rsp_tuser    // overflow
);

   logic        advance;
   logic [7:1]  valid_ff;

   // stage 1: input register
   mode_type    mode1_ff;
   quat16_type  a1_ff, b1_ff;
   // stages 2..4 carry a and mode beside the first product
   quat16_type  a2_ff, a3_ff, a4_ff;
   mode_type    mode2_ff, mode3_ff, mode4_ff, mode5_ff, mode6_ff, mode7_ff;
   // stage 4: intermediate t
   quat16_type  t4_ff, t4_in;
   logic        ovf4_ff, ovf4_in;
   // stages 5..7 carry t and its flag beside the second product
   quat16_type  t5_ff, t6_ff, t7_ff;
   logic        ovf5_ff, ovf6_ff, ovf7_ff;
   // stage 7: final rounding
   quat16_type  r7_ff, r7_in;
   logic        rovf7_ff, rovf7_in;

   quat17_type  p1, q1, p2, q2;
   quatsum_type sum1, sum2;
   rounded_type rt_w, rt_x, rt_y, rt_z, rr_x, rr_y, rr_z;
   quat16_type  pipe_data;
   logic        pipe_ovf;
   quat16_type  rsp_data;

   assign req_tready = advance;

   // valid bits travel with the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[6:1], req_tvalid};
      end
   end

   // input register; vector has a zero scalar when rotating
   always_ff @(posedge clock) begin
      if (advance) begin
         mode1_ff <= mode_type'(req_tuser);
         a1_ff.w  <= req_tdata[15:0];
         a1_ff.x  <= req_tdata[31:16];
         a1_ff.y  <= req_tdata[47:32];
         a1_ff.z  <= req_tdata[63:48];
         b1_ff.w  <= (mode_type'(req_tuser) == MODE_ROTATE) ? '0 : req_tdata[79:64];
         b1_ff.x  <= req_tdata[95:80];
         b1_ff.y  <= req_tdata[111:96];
         b1_ff.z  <= req_tdata[127:112];
      end
   end

   // first product a*b
   assign p1 = '{w: widen(a1_ff.w), x: widen(a1_ff.x), y: widen(a1_ff.y), z: widen(a1_ff.z)};
   assign q1 = '{w: widen(b1_ff.w), x: widen(b1_ff.x), y: widen(b1_ff.y), z: widen(b1_ff.z)};

   qmr_hprod u_hprod_first (
      .clock  (clock),
      .enable (advance),
      .p      (p1),
      .q      (q1),
      .sum    (sum1)
   );

   // round the intermediate t
   always_comb begin
      rt_w    = round_sat(sum1.w);
      rt_x    = round_sat(sum1.x);
      rt_y    = round_sat(sum1.y);
      rt_z    = round_sat(sum1.z);
      t4_in   = '{w: rt_w.value, x: rt_x.value, y: rt_y.value, z: rt_z.value};
      ovf4_in = rt_w.sat | rt_x.sat | rt_y.sat | rt_z.sat;
   end

   // side data beside the first product, then rounding register
   always_ff @(posedge clock) begin
      if (advance) begin
         a2_ff    <= a1_ff;
         a3_ff    <= a2_ff;
         a4_ff    <= a3_ff;
         mode2_ff <= mode1_ff;
         mode3_ff <= mode2_ff;
         mode4_ff <= mode3_ff;
         t4_ff    <= t4_in;
         ovf4_ff  <= ovf4_in;
      end
   end

   // second product t*conj(a); negation done one bit wider
   assign p2 = '{w: widen(t4_ff.w), x: widen(t4_ff.x), y: widen(t4_ff.y), z: widen(t4_ff.z)};
   assign q2 = '{w: widen(a4_ff.w), x: -widen(a4_ff.x), y: -widen(a4_ff.y),
                 z: -widen(a4_ff.z)};

   qmr_hprod u_hprod_second (
      .clock  (clock),
      .enable (advance),
      .p      (p2),
      .q      (q2),
      .sum    (sum2)
   );

   // final rounding; the scalar of the rotation is dropped
   always_comb begin
      rr_x     = round_sat(sum2.x);
      rr_y     = round_sat(sum2.y);
      rr_z     = round_sat(sum2.z);
      r7_in    = '{w: '0, x: rr_x.value, y: rr_y.value, z: rr_z.value};
      rovf7_in = rr_x.sat | rr_y.sat | rr_z.sat;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mode5_ff <= mode4_ff;
         mode6_ff <= mode5_ff;
         mode7_ff <= mode6_ff;
         t5_ff    <= t4_ff;
         t6_ff    <= t5_ff;
         t7_ff    <= t6_ff;
         ovf5_ff  <= ovf4_ff;
         ovf6_ff  <= ovf5_ff;
         ovf7_ff  <= ovf6_ff;
         r7_ff    <= r7_in;
         rovf7_ff <= rovf7_in;
      end
   end

   // pick the product or the rotation
   always_comb begin
      unique case (mode7_ff)
         MODE_PRODUCT: begin
            pipe_data = t7_ff;
            pipe_ovf  = ovf7_ff;
         end
         MODE_ROTATE: begin
            pipe_data = r7_ff;
            pipe_ovf  = ovf7_ff | rovf7_ff;
         end
         default: begin
            pipe_data = t7_ff;
            pipe_ovf  = ovf7_ff;
         end
      endcase
   end

   qmr_outbuf u_outbuf (
      .clock        (clock),
      .reset        (reset),
      .pipe_valid   (valid_ff[7]),
      .pipe_data    (pipe_data),
      .pipe_ovf     (pipe_ovf),
      .pipe_advance (advance),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_data     (rsp_data),
      .rsp_ovf      (rsp_tuser)
   );

   assign rsp_tdata = {rsp_data.z, rsp_data.y, rsp_data.x, rsp_data.w};

endmodule

// File: hw/rtl/qmr_hprod.sv
module qmr_hprod
   import qmr_pkg::*;
(
   input  logic        clock,
   input  logic        enable,
   input  quat17_type  p,
   input  quat17_type  q,
   output quatsum_type sum
);

   q17_type                    pv [4];
   q17_type                    qv [4];
   logic signed [ProdBits-1:0] prod_ff [4][4];
   logic signed [ProdBits-1:0] prod_in [4][4];
   quatsum_type                sum_ff;
   quatsum_type                sum_in;

   assign pv[0] = p.w;
   assign pv[1] = p.x;
   assign pv[2] = p.y;
   assign pv[3] = p.z;
   assign qv[0] = q.w;
   assign qv[1] = q.x;
   assign qv[2] = q.y;
   assign qv[3] = q.z;

   // all sixteen cross products, one multiplier each
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            prod_in[i][j] = pv[i] * qv[j];
         end
      end
   end

   // hamilton product terms, indices 0..3 = w, x, y, z
   always_comb begin
      sum_in.w = SumBits'(prod_ff[0][0]) - SumBits'(prod_ff[1][1])
               - SumBits'(prod_ff[2][2]) - SumBits'(prod_ff[3][3]);
      sum_in.x = SumBits'(prod_ff[0][1]) + SumBits'(prod_ff[1][0])
               + SumBits'(prod_ff[2][3]) - SumBits'(prod_ff[3][2]);
      sum_in.y = SumBits'(prod_ff[0][2]) + SumBits'(prod_ff[2][0])
               + SumBits'(prod_ff[3][1]) - SumBits'(prod_ff[1][3]);
      sum_in.z = SumBits'(prod_ff[0][3]) + SumBits'(prod_ff[3][0])
               + SumBits'(prod_ff[1][2]) - SumBits'(prod_ff[2][1]);
   end

   // product stage then sum stage
   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

// File: hw/rtl/qmr_outbuf.sv
module qmr_outbuf
   import qmr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       pipe_valid,
   input  quat16_type pipe_data,
   input  logic       pipe_ovf,
   output logic       pipe_advance,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output quat16_type rsp_data,
   output logic       rsp_ovf
);

   logic       out_valid_ff, out_valid_in;
   quat16_type out_data_ff, out_data_in;
   logic       out_ovf_ff, out_ovf_in;
   logic       skid_valid_ff, skid_valid_in;
   quat16_type skid_data_ff, skid_data_in;
   logic       skid_ovf_ff, skid_ovf_in;
   logic       out_take;

   // pipeline moves only while the skid slot is free
   assign pipe_advance = !skid_valid_ff;
   assign out_take     = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      out_ovf_in    = out_ovf_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      skid_ovf_in   = skid_ovf_ff;
      if (out_take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            out_ovf_in    = skid_ovf_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = pipe_valid;
            out_data_in  = pipe_data;
            out_ovf_in   = pipe_ovf;
         end
      end else if (!skid_valid_ff && pipe_valid) begin
         // output stalled, park the finished item
         skid_valid_in = 1'b1;
         skid_data_in  = pipe_data;
         skid_ovf_in   = pipe_ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      out_ovf_ff   <= out_ovf_in;
      skid_data_ff <= skid_data_in;
      skid_ovf_ff  <= skid_ovf_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_data   = out_data_ff;
   assign rsp_ovf    = out_ovf_ff;

endmodule

// File: verif/tb_top.sv
module tb_top
   import qmr_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // one input transfer: mode plus quaternions a and b
   typedef struct packed {
      mode_type   mode;
      quat16_type a;
      quat16_type b;
   } operands_type;

   // one result transfer: r plus the saturation flag
   typedef struct packed {
      quat16_type r;
      logic       ovf;
   } outcome_type;

   // exact-precision quaternion for the expected-value math
   typedef struct {
      longint w;
      longint x;
      longint y;
      longint z;
   } wide_quat_type;

   localparam longint Q12Half     = 2048;
   localparam int     NumRandom   = 1000;
   localparam int     NumDirected = 18;
   localparam int     Typed       = 1;
   localparam int     Model       = 0;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
   logic         req_tuser;   // mode
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [63:0]  rsp_tdata;   // r_w, r_x, r_y, r_z
   logic         rsp_tuser;   // overflow

   outcome_type pending_results[$];
   int          mismatch_count = 0;
   int          results_seen   = 0;
   logic        steady         = 1'b0;

   // directed table: mode, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
   // check kind, then r_w, r_x, r_y, r_z, overflow where the check is typed
   int directed_rows [NumDirected][15] = '{
      // all zero
      '{MODE_PRODUCT, 0, 0, 0, 0, 0, 0, 0, 0, Typed, 0, 0, 0, 0, 0},
      // identity on the left passes b through
      '{MODE_PRODUCT, 4096, 0, 0, 0, 1234, -5678, 32767, -32768,
        Typed, 1234, -5678, 32767, -32768, 0},
      // (-8)*(-8) saturates high
      '{MODE_PRODUCT, -32768, 0, 0, 0, -32768, 0, 0, 0, Typed, 32767, 0, 0, 0, 1},
      // all components at max
      '{MODE_PRODUCT, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
        Typed, -32768, 32767, 32767, 32767, 1},
      // all components at min
      '{MODE_PRODUCT, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
        Typed, -32768, 32767, 32767, 32767, 1},
      // i*j = k
      '{MODE_PRODUCT, 0, 4096, 0, 0, 0, 0, 4096, 0, Typed, 0, 0, 0, 4096, 0},
      // j*i = -k
      '{MODE_PRODUCT, 0, 0, 4096, 0, 0, 4096, 0, 0, Typed, 0, 0, 0, -4096, 0},
      // rounding at exactly one half, both signs
      '{MODE_PRODUCT, 1, 0, 0, 0, 2048, 0, 0, 0, Model, 0, 0, 0, 0, 0},
      '{MODE_PRODUCT, 1, 0, 0, 0, -2049, -2048, 2047, -2047, Model, 0, 0, 0, 0, 0},
      '{MODE_PRODUCT, -1, -1, -1, -1, 2048, 2048, 2048, 2048, Model, 0, 0, 0, 0, 0},
      '{MODE_PRODUCT, -32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768,
        Model, 0, 0, 0, 0, 0},
      // identity rotation, b_w must have no effect
      '{MODE_ROTATE, 4096, 0, 0, 0, -32768, 100, -200, 300, Typed, 0, 100, -200, 300, 0},
      // zero quaternion wipes the vector
      '{MODE_ROTATE, 0, 0, 0, 0, 32767, 32767, 32767, 32767, Typed, 0, 0, 0, 0, 0},
      // conjugate of -8.0 must not wrap
      '{MODE_ROTATE, 0, -32768, 0, 0, 5, 4096, 4096, 4096, Model, 0, 0, 0, 0, 0},
      // intermediate t saturates
      '{MODE_ROTATE, 32767, 32767, 32767, 32767, 0, 32767, 32767, 32767,
        Model, 0, 0, 0, 0, 0},
      '{MODE_ROTATE, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
        Model, 0, 0, 0, 0, 0},
      // quarter turn about z
      '{MODE_ROTATE, 2896, 0, 0, 2896, 7, 4096, 0, 0, Model, 0, 0, 0, 0, 0},
      '{MODE_ROTATE, 32767, -32768, 32767, -32768, 0, -32768, 32767, -32768,
        Model, 0, 0, 0, 0, 0}
   };

   quaternion_multiply_rotate dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // round half up to Q3.12 and clamp to 16 bits
   function automatic q16_type to_q12(input longint sum, inout logic sat);
      longint q;
      q = (sum + Q12Half) >>> QFrac;
      if (q > 32767) begin
         sat = 1'b1;
         return 16'sh7fff;
      end
      if (q < -32768) begin
         sat = 1'b1;
         return 16'sh8000;
      end
      return q16_type'(q);
   endfunction

   function automatic wide_quat_type to_wide(input quat16_type v);
      wide_quat_type r;
      r.w = v.w;
      r.x = v.x;
      r.y = v.y;
      r.z = v.z;
      return r;
   endfunction

   // rounded hamilton product p*q, scalar part only when asked for
   function automatic wide_quat_type hamilton(input wide_quat_type p,
                                              input wide_quat_type q,
                                              input logic with_w,
                                              inout logic sat);
      wide_quat_type r;
      r.w = 0;
      if (with_w) begin
         r.w = to_q12(p.w * q.w - p.x * q.x - p.y * q.y - p.z * q.z, sat);
      end
      r.x = to_q12(p.w * q.x + q.w * p.x + p.y * q.z - p.z * q.y, sat);
      r.y = to_q12(p.w * q.y + q.w * p.y + p.z * q.x - p.x * q.z, sat);
      r.z = to_q12(p.w * q.z + q.w * p.z + p.x * q.y - p.y * q.x, sat);
      return r;
   endfunction

   // expected output for one input transfer
   function automatic outcome_type quat_unit_result(input operands_type op);
      wide_quat_type a;
      wide_quat_type v;
      wide_quat_type t;
      wide_quat_type ac;
      wide_quat_type r;
      logic          sat;
      outcome_type   res;
      sat = 1'b0;
      a   = to_wide(op.a);
      v   = to_wide(op.b);
      if (op.mode == MODE_PRODUCT) begin
         r = hamilton(a, v, 1'b1, sat);
      end else begin
         // rotate: t = a*(0,v), then t*conj(a) without its scalar part
         v.w  = 0;
         t    = hamilton(a, v, 1'b1, sat);
         ac.w = a.w;
         ac.x = -a.x;
         ac.y = -a.y;
         ac.z = -a.z;
         r    = hamilton(t, ac, 1'b0, sat);
      end
      res.r.w = q16_type'(r.w);
      res.r.x = q16_type'(r.x);
      res.r.y = q16_type'(r.y);
      res.r.z = q16_type'(r.z);
      res.ovf = sat;
      return res;
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // component value: near unit scale, full range, or a corner value
   function automatic q16_type pick_component();
      int unsigned roll;
      int          corners[8];
      corners = '{-32768, -32767, -4096, -1, 0, 1, 4096, 32767};
      roll    = $urandom_range(0, 9);
      if (roll < 6) return q16_type'(int'($urandom_range(0, 8192)) - 4096);
      if (roll < 8) return q16_type'($urandom);
      return q16_type'(corners[$urandom_range(0, 7)]);
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("mismatch on result %0d: %s", results_seen, msg);
      mismatch_count++;
   endtask

   // drive one input transfer and queue its expected result on acceptance
   task automatic send_operands(input operands_type op, input logic known,
                                input outcome_type typed_res);
      int unsigned gap;
      gap = steady ? 0 : pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {op.b.z, op.b.y, op.b.x, op.b.w, op.a.z, op.a.y, op.a.x, op.a.w};
      req_tuser  <= op.mode;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(known ? typed_res : quat_unit_result(op));
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // receiver: ready runs broken by stalls of random length
   initial begin
      int unsigned run;
      int unsigned stall;
      forever begin
         run   = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 8);
         stall = pick_gap();
         rsp_tready <= 1'b1;
         repeat (run) @(posedge clock);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      outcome_type want;
      quat16_type  got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.w = rsp_tdata[15:0];
         got.x = rsp_tdata[31:16];
         got.y = rsp_tdata[47:32];
         got.z = rsp_tdata[63:48];
         if (pending_results.size() == 0) begin
            flag_mismatch("result with nothing expected");
         end else begin
            want = pending_results.pop_front();
            if (got.w !== want.r.w)
               flag_mismatch($sformatf("r_w got %0d want %0d", got.w, want.r.w));
            if (got.x !== want.r.x)
               flag_mismatch($sformatf("r_x got %0d want %0d", got.x, want.r.x));
            if (got.y !== want.r.y)
               flag_mismatch($sformatf("r_y got %0d want %0d", got.y, want.r.y));
            if (got.z !== want.r.z)
               flag_mismatch($sformatf("r_z got %0d want %0d", got.z, want.r.z));
            if (rsp_tuser !== want.ovf)
               flag_mismatch($sformatf("overflow got %b want %b", rsp_tuser, want.ovf));
         end
         results_seen++;
      end
   end

   // stimulus and end of run
   initial begin
      operands_type op;
      outcome_type  typed_res;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= MODE_PRODUCT;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < NumDirected; i++) begin
         op.mode       = mode_type'(directed_rows[i][0]);
         op.a.w        = q16_type'(directed_rows[i][1]);
         op.a.x        = q16_type'(directed_rows[i][2]);
         op.a.y        = q16_type'(directed_rows[i][3]);
         op.a.z        = q16_type'(directed_rows[i][4]);
         op.b.w        = q16_type'(directed_rows[i][5]);
         op.b.x        = q16_type'(directed_rows[i][6]);
         op.b.y        = q16_type'(directed_rows[i][7]);
         op.b.z        = q16_type'(directed_rows[i][8]);
         typed_res.r.w = q16_type'(directed_rows[i][10]);
         typed_res.r.x = q16_type'(directed_rows[i][11]);
         typed_res.r.y = q16_type'(directed_rows[i][12]);
         typed_res.r.z = q16_type'(directed_rows[i][13]);
         typed_res.ovf = directed_rows[i][14][0];
         send_operands(op, directed_rows[i][9] == Typed, typed_res);
      end

      // random items, with back-to-back stretches now and then
      typed_res = '0;
      for (int i = 0; i < NumRandom; i++) begin
         if (i % 50 == 0) steady = ($urandom_range(0, 3) == 0);
         op.mode = ($urandom_range(0, 1) == 1) ? MODE_ROTATE : MODE_PRODUCT;
         op.a.w  = pick_component();
         op.a.x  = pick_component();
         op.a.y  = pick_component();
         op.a.z  = pick_component();
         op.b.w  = pick_component();
         op.b.x  = pick_component();
         op.b.y  = pick_component();
         op.b.z  = pick_component();
         send_operands(op, 1'b0, typed_res);
      end
      req_tvalid <= 1'b0;

      // drain, then watch for stray results
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** quaternion_multiply_rotate: PASSED **");
      end else begin
         $display("** quaternion_multiply_rotate: FAILED **");
      end
      $finish;
   end

   // hang guard
   initial begin
      #10_000_000;
      $display("** quaternion_multiply_rotate: FAILED **");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/qmr_pkg.sv
hw/rtl/qmr_hprod.sv
hw/rtl/qmr_outbuf.sv
hw/rtl/quaternion_multiply_rotate.sv
verif/tb_top.sv
